/* sv/s2cal_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// s2cal_pkg: shared types and constants for the seconds-to-calendar block
// Holds the mode codes, the reciprocal constants for the divide-by-constant
// stages and the table of month start days.
// ----------------------------------------------------------------------------
package s2cal_pkg;

  typedef enum logic [2:0] {
    MODE_TIME     = 3'd0,
    MODE_DATE     = 3'd1,
    MODE_MONTH    = 3'd2,
    MODE_YEAR     = 3'd3,
    MODE_TIME_HEX = 3'd4,
    MODE_DATE_HEX = 3'd5
  } mode_t;

  // 86400 = 128 * 675; the low seven bits of the count pass straight into
  // the time of day.
  localparam int unsigned DAY_SHIFT      = 7;
  localparam int unsigned DAY_ODD        = 675;
  localparam int unsigned SECS_PER_HOUR  = 3600;
  localparam int unsigned SECS_PER_MIN   = 60;
  localparam int unsigned DAYS_PER_CYCLE = 1461;
  localparam int unsigned DAYS_PER_WEEK  = 7;
  localparam int unsigned WEEKDAY_OFFSET = 6;
  localparam int unsigned DAYS_LEAP_YEAR = 366;
  localparam int unsigned DAYS_YEAR      = 365;
  localparam int unsigned GREG_SKIP_YEAR = 100;

  // Floor reciprocals: quotient estimate is exact or one too small.
  localparam int unsigned RCP_DAY_SH   = 35;
  localparam logic [25:0] RCP_DAY      = 26'd50903316;  // 2^35 / 675
  localparam int unsigned RCP_HOUR_SH  = 29;
  localparam logic [17:0] RCP_HOUR     = 18'd149130;    // 2^29 / 3600
  localparam int unsigned RCP_CYCLE_SH = 32;
  localparam logic [21:0] RCP_CYCLE    = 22'd2939744;   // 2^32 / 1461
  localparam int unsigned RCP_WEEK_SH  = 19;
  localparam logic [16:0] RCP_WEEK     = 17'd74898;     // 2^19 / 7
  localparam int unsigned RCP_MIN_SH   = 18;
  localparam logic [12:0] RCP_MIN      = 13'd4369;      // 2^18 / 60

  localparam logic [3:0] FIRST_MONTH = 4'd1;
  localparam logic [3:0] LAST_SLOT   = 4'd13;

  // Days of the year that come before the first day of month m. Slot 13
  // exists because a 366-day year with a short February runs past December.
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] l;
    begin
      l = {8'd0, leap};
      case (m)
        4'd1:    month_start = 9'd0;
        4'd2:    month_start = 9'd31;
        4'd3:    month_start = 9'd59 + l;
        4'd4:    month_start = 9'd90 + l;
        4'd5:    month_start = 9'd120 + l;
        4'd6:    month_start = 9'd151 + l;
        4'd7:    month_start = 9'd181 + l;
        4'd8:    month_start = 9'd212 + l;
        4'd9:    month_start = 9'd243 + l;
        4'd10:   month_start = 9'd273 + l;
        4'd11:   month_start = 9'd304 + l;
        4'd12:   month_start = 9'd334 + l;
        4'd13:   month_start = 9'd365 + l;
        default: month_start = 9'd0;
      endcase
    end
  endfunction

endpackage
`default_nettype wire

/* sv/seconds_to_calendar_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// seconds_to_calendar_top: epoch seconds to time of day and calendar date
// Splits a 32-bit seconds count into time of day, weekday, year offset,
// month and day, and returns one packed value chosen by the mode.
// ----------------------------------------------------------------------------
// Usage:
// The item channel carries epoch_seconds and mode; an item is taken at a
// rising edge where item_valid is high and item_stall is low. The result
// channel carries packed_value and the broken-down fields under result_valid
// and result_stall in the same way.
// The block is an eleven-register pipeline: the input register, nine work
// stages and the result register. One item is taken every cycle for as
// long as the receiver takes results. Each divide-by-constant step
// (reciprocal multiply, then a subtract, then a single compare-and-correct)
// is spread over successive stages, which sets the stage count.
// A synchronous reset clears all valid bits; the pipeline is then empty and
// ready at once. When the receiver stalls with a result waiting, every stage
// holds and item_stall rises in the same cycle, so the waiting result and
// all items in flight stay put until the stall drops.
// A count of zero gives a packed value of zero in every mode, with day 1,
// month 1 and weekday 6. Both hex modes and the unused codes give zero.
// ----------------------------------------------------------------------------
module seconds_to_calendar_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [31:0] epoch_seconds,
  input  logic [2:0]  mode,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [18:0] packed_value,
  output logic [5:0]  second_out,
  output logic [5:0]  minute_out,
  output logic [4:0]  hour_out,
  output logic [4:0]  day_out,
  output logic [3:0]  month_out,
  output logic [2:0]  weekday_out,
  output logic [7:0]  year_out
);
  import s2cal_pkg::*;

  // The whole pipeline moves as one: it advances unless a finished result
  // is waiting on a stalled receiver. Bubbles travel along with the items.
  logic adv;
  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv;

  // Valid, mode and zero-count flags ride along the stages beside the data.
  logic [10:1]      vld;
  logic [2:0]       mode_p [1:10];
  logic [10:2]      zero_p;
  logic [31:0]      s1_secs;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result_valid <= 1'b0;
    end else if (adv) begin
      vld          <= {vld[9:1], item_valid};
      result_valid <= vld[10];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_p[1] <= mode;
      for (int i = 2; i <= 10; i++) begin
        mode_p[i] <= mode_p[i-1];
      end
      zero_p <= {zero_p[9:2], (s1_secs == 32'd0)};
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_secs <= epoch_seconds;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Day estimate: (secs >> 7) / 675 by reciprocal multiply.
  logic [50:0] day_prod;
  logic [31:0] s2_secs;
  logic [15:0] s2_q0;
  assign day_prod = {26'd0, s1_secs[31:DAY_SHIFT]} * {25'd0, RCP_DAY};

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_secs <= s1_secs;
      s2_q0   <= day_prod[RCP_DAY_SH +: 16];
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [25:0] day_rem;
  logic [6:0]  s3_low;
  logic [15:0] s3_q0;
  logic [10:0] s3_r0;
  assign day_rem = {1'b0, s2_secs[31:DAY_SHIFT]} - ({10'd0, s2_q0} * 26'(DAY_ODD));

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_low <= s2_secs[DAY_SHIFT-1:0];
      s3_q0  <= s2_q0;
      s3_r0  <= day_rem[10:0];
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Correct the day estimate; the remainder times 128 plus the low bits is
  // the second of the day.
  logic        day_fix;
  logic [10:0] day_rl;
  logic [15:0] s4_days;
  logic [16:0] s4_tod;
  assign day_fix = (s3_r0 >= 11'(DAY_ODD));
  assign day_rl  = day_fix ? (s3_r0 - 11'(DAY_ODD)) : s3_r0;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_days <= day_fix ? (s3_q0 + 16'd1) : s3_q0;
      s4_tod  <= {day_rl[9:0], s3_low};
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Three independent quotient estimates: hour, 4-year cycle and week.
  logic [34:0] hour_prod;
  logic [37:0] cyc_prod;
  logic [32:0] week_prod;
  logic [15:0] week_days;
  assign week_days = s4_days + 16'(WEEKDAY_OFFSET);
  assign hour_prod = {18'd0, s4_tod} * {17'd0, RCP_HOUR};
  assign cyc_prod  = {22'd0, s4_days} * {16'd0, RCP_CYCLE};
  assign week_prod = {17'd0, week_days} * {16'd0, RCP_WEEK};

  logic [15:0] s5_days;
  logic [16:0] s5_tod;
  logic [5:0]  s5_hq0;
  logic [5:0]  s5_cq0;
  logic [13:0] s5_wq0;
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_days <= s4_days;
      s5_tod  <= s4_tod;
      s5_hq0  <= hour_prod[RCP_HOUR_SH +: 6];
      s5_cq0  <= cyc_prod[RCP_CYCLE_SH +: 6];
      s5_wq0  <= week_prod[RCP_WEEK_SH +: 14];
    end
  end

  // ---------------------------------------------------------------- stage 6
  logic [17:0] hour_rem;
  logic [15:0] cyc_rem;
  logic [15:0] week_rem;
  assign hour_rem = {1'b0, s5_tod} - ({12'd0, s5_hq0} * 18'(SECS_PER_HOUR));
  assign cyc_rem  = s5_days - ({10'd0, s5_cq0} * 16'(DAYS_PER_CYCLE));
  assign week_rem = (s5_days + 16'(WEEKDAY_OFFSET)) - ({2'd0, s5_wq0} * 16'(DAYS_PER_WEEK));

  logic [5:0]  s6_hq0;
  logic [5:0]  s6_cq0;
  logic [12:0] s6_hr0;
  logic [11:0] s6_cr0;
  logic [3:0]  s6_wr0;
  always_ff @(posedge clk) begin
    if (adv) begin
      s6_hq0 <= s5_hq0;
      s6_cq0 <= s5_cq0;
      s6_hr0 <= hour_rem[12:0];
      s6_cr0 <= cyc_rem[11:0];
      s6_wr0 <= week_rem[3:0];
    end
  end

  // ---------------------------------------------------------------- stage 7
  logic        hour_fix;
  logic        cyc_fix;
  logic [12:0] hrem_c;
  logic [11:0] cr_c;
  logic [3:0]  wr_c;
  logic [5:0]  hour_c;
  assign hour_fix = (s6_hr0 >= 13'(SECS_PER_HOUR));
  assign cyc_fix  = (s6_cr0 >= 12'(DAYS_PER_CYCLE));
  assign hrem_c   = hour_fix ? (s6_hr0 - 13'(SECS_PER_HOUR)) : s6_hr0;
  assign cr_c     = cyc_fix ? (s6_cr0 - 12'(DAYS_PER_CYCLE)) : s6_cr0;
  assign wr_c     = (s6_wr0 >= 4'(DAYS_PER_WEEK)) ? (s6_wr0 - 4'(DAYS_PER_WEEK)) : s6_wr0;
  assign hour_c   = hour_fix ? (s6_hq0 + 6'd1) : s6_hq0;

  logic [4:0]  s7_hour;
  logic [11:0] s7_hrem;
  logic [5:0]  s7_cyc;
  logic [10:0] s7_cr;
  logic [2:0]  s7_wday;
  always_ff @(posedge clk) begin
    if (adv) begin
      s7_hour <= hour_c[4:0];
      s7_hrem <= hrem_c[11:0];
      s7_cyc  <= cyc_fix ? (s6_cq0 + 6'd1) : s6_cq0;
      s7_cr   <= cr_c[10:0];
      s7_wday <= wr_c[2:0];
    end
  end

  // ---------------------------------------------------------------- stage 8
  // Minute estimate, and the year within the cycle: the first year of each
  // cycle has 366 days, the other three 365.
  logic [24:0] min_prod;
  logic [1:0]  yy;
  logic [10:0] yy_base;
  assign min_prod = {13'd0, s7_hrem} * {12'd0, RCP_MIN};

  always_comb begin
    if (s7_cr < 11'(DAYS_LEAP_YEAR)) begin
      yy      = 2'd0;
      yy_base = 11'd0;
    end else if (s7_cr < 11'(DAYS_LEAP_YEAR + DAYS_YEAR)) begin
      yy      = 2'd1;
      yy_base = 11'(DAYS_LEAP_YEAR);
    end else if (s7_cr < 11'(DAYS_LEAP_YEAR + 2 * DAYS_YEAR)) begin
      yy      = 2'd2;
      yy_base = 11'(DAYS_LEAP_YEAR + DAYS_YEAR);
    end else begin
      yy      = 2'd3;
      yy_base = 11'(DAYS_LEAP_YEAR + 2 * DAYS_YEAR);
    end
  end

  logic [10:0] doy_full;
  assign doy_full = s7_cr - yy_base;

  logic [4:0]  s8_hour;
  logic [11:0] s8_hrem;
  logic [5:0]  s8_mq0;
  logic [2:0]  s8_wday;
  logic [7:0]  s8_year;
  logic [8:0]  s8_doy;
  always_ff @(posedge clk) begin
    if (adv) begin
      s8_hour <= s7_hour;
      s8_hrem <= s7_hrem;
      s8_mq0  <= min_prod[RCP_MIN_SH +: 6];
      s8_wday <= s7_wday;
      s8_year <= {s7_cyc, 2'b00} + {6'd0, yy};
      s8_doy  <= doy_full[8:0];
    end
  end

  // ---------------------------------------------------------------- stage 9
  // Minute and second, and the month by comparing the day of the year with
  // every month start at once. February follows the Gregorian test on the
  // year offset, which within range fails only at offset 100.
  logic [11:0] min_rem;
  logic [6:0]  mr0;
  logic        min_fix;
  logic [6:0]  sec_c;
  logic        leap;
  logic [8:0]  dom;
  logic [3:0]  month_c;
  assign min_rem = s8_hrem - ({6'd0, s8_mq0} * 12'(SECS_PER_MIN));
  assign mr0     = min_rem[6:0];
  assign min_fix = (mr0 >= 7'(SECS_PER_MIN));
  assign sec_c   = min_fix ? (mr0 - 7'(SECS_PER_MIN)) : mr0;
  assign leap    = (s8_year[1:0] == 2'd0) && (s8_year != 8'(GREG_SKIP_YEAR));
  assign dom     = s8_doy + 9'd1;

  always_comb begin
    month_c = FIRST_MONTH;
    for (int k = 2; k <= int'(LAST_SLOT); k++) begin
      if (dom > month_start(4'(k), leap)) begin
        month_c = month_c + 4'd1;
      end
    end
  end

  logic [4:0] s9_hour;
  logic [5:0] s9_minute;
  logic [5:0] s9_second;
  logic [2:0] s9_wday;
  logic [7:0] s9_year;
  logic [3:0] s9_month;
  logic [8:0] s9_dom;
  logic       s9_leap;
  always_ff @(posedge clk) begin
    if (adv) begin
      s9_hour   <= s8_hour;
      s9_minute <= min_fix ? (s8_mq0 + 6'd1) : s8_mq0;
      s9_second <= sec_c[5:0];
      s9_wday   <= s8_wday;
      s9_year   <= s8_year;
      s9_month  <= month_c;
      s9_dom    <= dom;
      s9_leap   <= leap;
    end
  end

  // --------------------------------------------------------------- stage 10
  logic [8:0] day_full;
  assign day_full = s9_dom - month_start(s9_month, s9_leap);

  logic [4:0] s10_hour;
  logic [5:0] s10_minute;
  logic [5:0] s10_second;
  logic [2:0] s10_wday;
  logic [7:0] s10_year;
  logic [3:0] s10_month;
  logic [4:0] s10_day;
  always_ff @(posedge clk) begin
    if (adv) begin
      s10_hour   <= s9_hour;
      s10_minute <= s9_minute;
      s10_second <= s9_second;
      s10_wday   <= s9_wday;
      s10_year   <= s9_year;
      s10_month  <= s9_month;
      s10_day    <= day_full[4:0];
    end
  end

  // ----------------------------------------------------------- result stage
  // A zero count forces the packed value to zero in every mode.
  logic [18:0] packed_c;
  always_comb begin
    case (mode_t'(mode_p[10]))
      MODE_TIME:     packed_c = ({14'd0, s10_hour} * 19'd10000)
                              + ({13'd0, s10_minute} * 19'd100)
                              + {13'd0, s10_second};
      MODE_DATE:     packed_c = ({14'd0, s10_day} * 19'd10000)
                              + ({15'd0, s10_month} * 19'd100)
                              + {11'd0, s10_year};
      MODE_MONTH:    packed_c = {15'd0, s10_month};
      MODE_YEAR:     packed_c = {11'd0, s10_year};
      MODE_TIME_HEX,
      MODE_DATE_HEX: packed_c = '0;
      default:       packed_c = '0;
    endcase
    if (zero_p[10]) begin
      packed_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      packed_value <= packed_c;
      second_out   <= s10_second;
      minute_out   <= s10_minute;
      hour_out     <= s10_hour;
      day_out      <= s10_day;
      month_out    <= s10_month;
      weekday_out  <= s10_wday;
      year_out     <= s10_year;
    end
  end

endmodule
`default_nettype wire

/* tb/sv/seconds_to_calendar_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seconds_to_calendar_top_tb: self-checking bench for the calendar converter
// Drives epoch second counts and modes through the item channel with bursty
// traffic, stalls the result channel on a shifting pattern, and checks every
// result field against a behavioral calendar computed inside the bench.
// ----------------------------------------------------------------------------
module seconds_to_calendar_top_tb;
  import s2cal_pkg::*;

  // Codes 6 and 7 are not defined modes, but the port can carry them and the
  // block must answer them with a zero packed value.
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam int unsigned SECS_PER_DAY   = 86400;
  localparam int unsigned DAYS_IN_CYCLE  = 1461;
  // Offset 100 is a 366-day year that fails the Gregorian February test.
  localparam int unsigned SKIP_YEAR      = 100;
  localparam int unsigned SKIP_YEAR_DAY0 = 36525;

  localparam int unsigned RANDOM_ITEMS   = 1150;
  localparam int unsigned MAX_GAP        = 16;
  // The pipeline is eleven registers deep; the tail wait leaves some margin.
  localparam int unsigned DRAIN_CYCLES   = 40;
  // Longest quiet spell in a correct run is a sender gap or a receiver stall
  // run; this limit is far above either.
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  // One result item as the block presents it.
  typedef struct packed {
    logic [18:0] packed_value;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [2:0]  weekday;
    logic [7:0]  year;
  } calendar_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [31:0] epoch_seconds = '0;
  logic [2:0]  mode = MODE_TIME;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [18:0] packed_value;
  logic [5:0]  second_out;
  logic [5:0]  minute_out;
  logic [4:0]  hour_out;
  logic [4:0]  day_out;
  logic [3:0]  month_out;
  logic [2:0]  weekday_out;
  logic [7:0]  year_out;

  // Expected calendars, oldest first, in the order items were accepted.
  calendar_t   calendar_q[$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;

  seconds_to_calendar_top uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .epoch_seconds(epoch_seconds),
    .mode         (mode),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .packed_value (packed_value),
    .second_out   (second_out),
    .minute_out   (minute_out),
    .hour_out     (hour_out),
    .day_out      (day_out),
    .month_out    (month_out),
    .weekday_out  (weekday_out),
    .year_out     (year_out)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Calendar prediction
  // --------------------------------------------------------------------------

  // February takes the Gregorian test on the year offset, even though the
  // year lengths follow the plain four-year rule. Slot 13 only exists for the
  // day that spills past December in a year like offset 100.
  function automatic int unsigned days_in_month(input int unsigned mon,
                                                input int unsigned yr);
    case (mon)
      4, 6, 9, 11: days_in_month = 30;
      2, 13: begin
        if ((yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0)))
          days_in_month = 29;
        else
          days_in_month = 28;
      end
      default: days_in_month = 31;
    endcase
  endfunction

  function automatic calendar_t predict_calendar(input logic [31:0] secs,
                                                 input logic [2:0]  op);
    int unsigned count, tod, hh, mm, ss, days, wd, yr, doy, dom, mon, mlen, pk;
    calendar_t   c;
    count = secs;
    tod   = count % SECS_PER_DAY;
    hh    = tod / 3600;
    mm    = (tod % 3600) / 60;
    ss    = tod % 60;
    days  = count / SECS_PER_DAY;
    wd    = (days + 6) % 7;
    yr    = 4 * (days / DAYS_IN_CYCLE);
    doy   = days % DAYS_IN_CYCLE;
    // The first year of each cycle is the long one.
    if (doy >= 366) begin
      doy = doy - 366;
      yr  = yr + 1 + doy / 365;
      doy = doy % 365;
    end
    dom  = doy + 1;
    mon  = 1;
    mlen = 31;
    while (dom > mlen && mon < 13) begin
      mon  = mon + 1;
      dom  = dom - mlen;
      mlen = days_in_month(mon, yr);
    end
    // A zero count means no data: the packed value is built from all-zero
    // fields, while the fields themselves report January 1 and weekday 6.
    if (count == 0) begin
      hh = 0; mm = 0; ss = 0; yr = 0;
      dom = 0; mon = 0; wd = 0;
    end
    case (op)
      MODE_TIME:  pk = hh * 10000 + mm * 100 + ss;
      MODE_DATE:  pk = dom * 10000 + mon * 100 + yr;
      MODE_MONTH: pk = mon;
      MODE_YEAR:  pk = yr;
      default:    pk = 0;
    endcase
    c.packed_value = pk[18:0];
    c.second       = ss[5:0];
    c.minute       = mm[5:0];
    c.hour         = hh[4:0];
    c.year         = yr[7:0];
    if (dom == 0) begin
      c.day     = 5'd1;
      c.month   = 4'd1;
      c.weekday = 3'd6;
    end else begin
      c.day     = dom[4:0];
      c.month   = mon[3:0];
      c.weekday = wd[2:0];
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Item sender
  // --------------------------------------------------------------------------

  // Sends one item and returns at the edge where it was taken. Traffic comes
  // in bursts; between bursts valid drops for a random gap, and about a third
  // of the bursts follow the previous one with no gap at all. Long bursts now
  // and then give stretches with no idling on the sender side.
  task automatic send_item(input logic [31:0] secs, input logic [2:0] op);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0)
        burst_left = $urandom_range(60, 150);
      else
        burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    item_valid    <= 1'b1;
    epoch_seconds <= secs;
    mode          <= op;
    // The payload holds steady until the block takes it.
    @(posedge clk);
    while (item_stall) @(posedge clk);
    calendar_q.push_back(predict_calendar(secs, op));
    burst_left = burst_left - 1;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus generators for the random part
  // --------------------------------------------------------------------------

  // A count that lands near a year boundary, at the end of February, or
  // anywhere in a chosen year. Offset 100 is picked often so that its last
  // day, which spills into a thirteenth month, comes up regularly.
  function automatic logic [31:0] year_edge_count();
    longint unsigned yr, first_day, year_days, day, cnt;
    yr = ($urandom_range(0, 7) == 0) ? SKIP_YEAR : $urandom_range(0, 135);
    if (yr % 4 == 0)
      first_day = (yr / 4) * DAYS_IN_CYCLE;
    else
      first_day = (yr / 4) * DAYS_IN_CYCLE + 366 + (yr % 4 - 1) * 365;
    year_days = (yr % 4 == 0) ? 366 : 365;
    case ($urandom_range(0, 3))
      0:       day = first_day + $urandom_range(0, 1);
      1:       day = first_day + year_days - 1 - $urandom_range(0, 1);
      2:       day = first_day + $urandom_range(57, 60);
      default: day = first_day + $urandom_range(0, year_days - 1);
    endcase
    cnt = day * SECS_PER_DAY + $urandom_range(0, SECS_PER_DAY - 1);
    // The final year is cut short by the 32-bit range.
    if (cnt > 64'hFFFF_FFFF)
      cnt = $urandom;
    return cnt[31:0];
  endfunction

  // A count on or next to a second, minute, hour or day rollover.
  function automatic logic [31:0] day_edge_count();
    int unsigned d, offs;
    d = $urandom_range(0, 49709);
    case ($urandom_range(0, 6))
      0:       offs = 0;
      1:       offs = 1;
      2:       offs = 59;
      3:       offs = 60;
      4:       offs = 3599;
      5:       offs = 3600;
      default: offs = SECS_PER_DAY - 1;
    endcase
    return d * SECS_PER_DAY + offs;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // A zero count in every mode code, the spare ones included.
  task automatic test_zero_count();
    for (int code = MODE_TIME; code <= MODE_SPARE_HI; code++)
      send_item(32'd0, code[2:0]);
  endtask

  // Smallest nonzero count, the last second of the first day, the first
  // second of the next, and the all-ones count in each defined mode.
  task automatic test_clock_extremes();
    send_item(32'd1, MODE_TIME);
    send_item(SECS_PER_DAY - 1, MODE_TIME);
    send_item(SECS_PER_DAY, MODE_DATE);
    send_item(32'hFFFF_FFFF, MODE_TIME);
    send_item(32'hFFFF_FFFF, MODE_DATE);
    send_item(32'hFFFF_FFFF, MODE_MONTH);
    send_item(32'hFFFF_FFFF, MODE_YEAR);
    send_item(32'hFFFF_FFFF, MODE_TIME_HEX);
    send_item(32'hFFFF_FFFF, MODE_DATE_HEX);
  endtask

  // Leap day of the first year, its last day, the start of the second year,
  // and the end of offset 100, where a short February pushes the final day
  // into month 13.
  task automatic test_calendar_edges();
    send_item(59 * SECS_PER_DAY + SECS_PER_DAY / 2, MODE_DATE);
    send_item(365 * SECS_PER_DAY, MODE_DATE);
    send_item(366 * SECS_PER_DAY, MODE_YEAR);
    send_item((SKIP_YEAR_DAY0 + 364) * SECS_PER_DAY, MODE_DATE);
    send_item((SKIP_YEAR_DAY0 + 365) * SECS_PER_DAY, MODE_DATE);
    send_item((SKIP_YEAR_DAY0 + 365) * SECS_PER_DAY + SECS_PER_DAY - 1, MODE_MONTH);
    send_item((SKIP_YEAR_DAY0 + 365) * SECS_PER_DAY + SECS_PER_DAY - 1, MODE_TIME);
  endtask

  // Uniform counts for four in ten items, with half aimed at calendar and clock
  // rollovers and a few small counts that now and then hit zero.
  task automatic test_random_counts();
    logic [31:0] secs;
    logic [2:0]  op;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: secs = $urandom;
        4, 5, 6:    secs = year_edge_count();
        7, 8:       secs = day_edge_count();
        default:    secs = $urandom_range(0, 200);
      endcase
      if ($urandom_range(0, 19) == 0)
        op = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      else
        op = 3'($urandom_range(MODE_TIME, MODE_DATE_HEX));
      send_item(secs, op);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result receiver: the stall style is redrawn whenever its run ends, from no
  // stalls at all to a heavy random load or a fixed rhythm.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : stall_pattern
    static stall_style_t style = STALL_NONE;
    static int unsigned  style_left = 0;
    static int unsigned  phase = 0;
    if (style_left == 0) begin
      style      = stall_style_t'($urandom_range(0, 3));
      style_left = $urandom_range(16, 200);
    end else begin
      style_left = style_left - 1;
    end
    phase = phase + 1;
    case (style)
      STALL_NONE:  result_stall <= 1'b0;
      STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: result_stall <= ($urandom_range(0, 9) < 7);
      default:     result_stall <= ((phase % 8) < 3);
    endcase
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted result is matched against the oldest
  // expected calendar. The values read here are those before this edge's
  // updates, which is exactly what the handshake saw.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    calendar_t got;
    calendar_t want;
    if (!rst && result_valid && !result_stall) begin
      got = '{packed_value, second_out, minute_out, hour_out,
              day_out, month_out, weekday_out, year_out};
      if (calendar_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result with no item pending: packed %0d", $realtime,
                   got.packed_value);
      end else begin
        want = calendar_q.pop_front();
        if (got.packed_value !== want.packed_value || got.second !== want.second ||
            got.minute !== want.minute || got.hour !== want.hour ||
            got.day !== want.day || got.month !== want.month ||
            got.weekday !== want.weekday || got.year !== want.year) begin
          mismatches = mismatches + 1;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: mismatch (packed sec min hour day month wday year)",
                     $realtime);
            $display("  expected %0d %0d %0d %0d %0d %0d %0d %0d",
                     want.packed_value, want.second, want.minute, want.hour,
                     want.day, want.month, want.weekday, want.year);
            $display("  actual   %0d %0d %0d %0d %0d %0d %0d %0d",
                     got.packed_value, got.second, got.minute, got.hour,
                     got.day, got.month, got.weekday, got.year);
          end
        end
      end
    end
  end

  // The watchdog ends a run that stops moving: it counts cycles in which
  // neither channel completes a handshake.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_zero_count();
    test_clock_extremes();
    test_calendar_edges();
    test_random_counts();

    // Stop sending and let every result in flight come out.
    item_valid <= 1'b0;
    while (calendar_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && calendar_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* seconds_to_calendar_top.f */
sv/s2cal_pkg.sv
sv/seconds_to_calendar_top.sv
tb/sv/seconds_to_calendar_top_tb.sv
